// ----- hdl/ps2mt_pkg.sv -----
// Shared types and constants for the PS/2 mouse packet tracker.
`default_nettype none
package ps2mt_pkg;

   localparam int RING_DEPTH  = 128;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int DELTA_W = 10;
   localparam int POS_W   = 12;
   localparam int BTN_W   = 3;

   localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd799;
   localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd599;
   localparam logic [POS_W-1:0] X_POS_RESET   = 12'd400;
   localparam logic [POS_W-1:0] Y_POS_RESET   = 12'd300;

   localparam int X_SIGN_BIT = 4;
   localparam int Y_SIGN_BIT = 5;
   localparam int X_OVF_BIT  = 6;
   localparam int Y_OVF_BIT  = 7;

   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 10'sd255;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = -10'sd255;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic CSR_X_LIMIT = 1'b0;
   localparam logic CSR_Y_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_PACKET,
      CMD_POP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [DELTA_W-1:0]  dx;
      logic signed [DELTA_W-1:0]  dy;
      logic [BTN_W-1:0]           buttons;
   } cmd_type;

   typedef struct packed {
      logic signed [DELTA_W-1:0]  dx;
      logic signed [DELTA_W-1:0]  dy;
      logic [BTN_W-1:0]           buttons;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage
`default_nettype wire

// ----- hdl/ps2mt_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface ps2mt_req_if;
   import ps2mt_pkg::*;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   modport source (output valid, req_type, data_byte, input ready);
   modport sink   (input valid, req_type, data_byte, output ready);
endinterface

interface ps2mt_rsp_if;
   import ps2mt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      event_valid;
   logic signed [DELTA_W-1:0] event_dx;
   logic signed [DELTA_W-1:0] event_dy;
   logic [BTN_W-1:0]          event_buttons;
   logic [POS_W-1:0]          position_x;
   logic [POS_W-1:0]          position_y;
   logic [BTN_W-1:0]          button_state;
   logic signed [DELTA_W-1:0] move_dx;
   logic signed [DELTA_W-1:0] move_dy;
   logic                      packet_done;
   logic                      event_dropped;
   logic                      has_event;
   modport source (output valid, event_valid, event_dx, event_dy, event_buttons,
                   position_x, position_y, button_state, move_dx, move_dy,
                   packet_done, event_dropped, has_event, input ready);
   modport sink   (input valid, event_valid, event_dx, event_dy, event_buttons,
                   position_x, position_y, button_state, move_dx, move_dy,
                   packet_done, event_dropped, has_event, output ready);
endinterface
`default_nettype wire

// ----- hdl/ps2mt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ps2mt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ps2mt_front.sv -----
// Front end: accepts beats, assembles three-byte packets and decodes deltas.
`default_nettype none
module ps2mt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   ps2mt_req_if.sink                req_bus,
   output logic                     cmd_valid,
   output ps2mt_pkg::cmd_type       cmd,
   input  wire logic                cmd_ready
);
   import ps2mt_pkg::*;

   logic [1:0] byte_count_ff, byte_count_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       fire;

   function automatic logic signed [DELTA_W-1:0] decode_delta(
      input logic ovf, input logic neg, input logic [7:0] low);
      logic signed [DELTA_W-1:0] d;
      if (ovf) begin
         d = neg ? DELTA_MIN : DELTA_MAX;
      end else begin
         d = {neg, neg, low};
      end
      return d;
   endfunction

   assign req_bus.ready = cmd_ready;
   assign cmd_valid     = req_bus.valid;
   assign fire          = req_bus.valid && cmd_ready;

   always_comb begin
      byte_count_in = byte_count_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      cmd.kind      = CMD_BYTE;
      cmd.dx        = decode_delta(first_ff[X_OVF_BIT], first_ff[X_SIGN_BIT], second_ff);
      cmd.dy        = -decode_delta(first_ff[Y_OVF_BIT], first_ff[Y_SIGN_BIT],
                                    req_bus.data_byte);
      cmd.buttons   = first_ff[BTN_W-1:0];
      if (req_bus.req_type == REQ_POP) begin
         cmd.kind = CMD_POP;
      end else begin
         case (byte_count_ff)
            2'd0: begin
               first_in      = req_bus.data_byte;
               byte_count_in = 2'd1;
            end
            2'd1: begin
               second_in     = req_bus.data_byte;
               byte_count_in = 2'd2;
            end
            default: begin
               cmd.kind      = CMD_PACKET;
               byte_count_in = 2'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 2'd0;
         first_ff      <= 8'd0;
         second_ff     <= 8'd0;
      end else if (fire) begin
         byte_count_ff <= byte_count_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ps2mt_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module ps2mt_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire ps2mt_pkg::cmd_type  in_cmd,
   output logic                     in_ready,
   output logic                     out_valid,
   output ps2mt_pkg::cmd_type       out_cmd,
   input  wire logic                out_ready
);
   import ps2mt_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff;
   logic                push, pop;

   assign in_ready  = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ps2mt_back.sv -----
// Back end: position tracking, event ring and response register.
`default_nettype none
module ps2mt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_valid,
   input  wire ps2mt_pkg::cmd_type  cmd,
   output logic                     cmd_ready,
   input  wire logic [11:0]         x_limit,
   input  wire logic [11:0]         y_limit,
   ps2mt_rsp_if.source              rsp_bus
);
   import ps2mt_pkg::*;

   logic [POS_W-1:0]          pos_x_ff, pos_x_in;
   logic [POS_W-1:0]          pos_y_ff, pos_y_in;
   logic [BTN_W-1:0]          buttons_ff, buttons_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [RING_AW-1:0]        head_ff, head_in;
   logic [RING_AW-1:0]        tail_ff, tail_in;
   logic                      out_valid_ff;
   logic                      hit_ff, hit_in;
   logic                      done_ff, done_in;
   logic                      dropped_ff, dropped_in;
   logic                      fire;
   logic                      ring_wr, ring_rd;
   logic [RING_AW-1:0]        tail_next, head_next;
   entry_type                 wr_entry, rd_entry;

   function automatic logic [POS_W-1:0] clamp_pos(
      input logic [POS_W-1:0] pos, input logic signed [DELTA_W-1:0] d,
      input logic [POS_W-1:0] limit);
      logic signed [POS_W+1:0] sum;
      logic [POS_W-1:0]        p;
      sum = $signed({2'b00, pos}) + $signed({{(POS_W+2-DELTA_W){d[DELTA_W-1]}}, d});
      if (sum < 0) begin
         p = '0;
      end else if (sum > $signed({2'b00, limit})) begin
         p = limit;
      end else begin
         p = sum[POS_W-1:0];
      end
      return p;
   endfunction

   assign cmd_ready = !out_valid_ff || rsp_bus.ready;
   assign fire      = cmd_valid && cmd_ready;
   assign tail_next = (tail_ff == RING_AW'(RING_DEPTH-1)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == RING_AW'(RING_DEPTH-1)) ? '0 : head_ff + 1'b1;

   assign wr_entry.dx      = cmd.dx;
   assign wr_entry.dy      = cmd.dy;
   assign wr_entry.buttons = cmd.buttons;

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      buttons_in = buttons_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      hit_in     = 1'b0;
      done_in    = 1'b0;
      dropped_in = 1'b0;
      ring_wr    = 1'b0;
      ring_rd    = 1'b0;
      case (cmd.kind)
         CMD_POP: begin
            if (head_ff != tail_ff) begin
               ring_rd = fire;
               hit_in  = 1'b1;
               head_in = head_next;
            end
         end
         CMD_PACKET: begin
            done_in    = 1'b1;
            buttons_in = cmd.buttons;
            dx_in      = cmd.dx;
            dy_in      = cmd.dy;
            pos_x_in   = clamp_pos(pos_x_ff, cmd.dx, x_limit);
            pos_y_in   = clamp_pos(pos_y_ff, cmd.dy, y_limit);
            if (tail_next != head_ff) begin
               ring_wr = fire;
               tail_in = tail_next;
            end else begin
               dropped_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   ps2mt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (tail_ff),
      .wr_data (wr_entry),
      .rd_en   (ring_rd),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= X_POS_RESET;
         pos_y_ff     <= Y_POS_RESET;
         buttons_ff   <= '0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         done_ff      <= 1'b0;
         dropped_ff   <= 1'b0;
      end else begin
         if (fire) begin
            pos_x_ff   <= pos_x_in;
            pos_y_ff   <= pos_y_in;
            buttons_ff <= buttons_in;
            dx_ff      <= dx_in;
            dy_ff      <= dy_in;
            head_ff    <= head_in;
            tail_ff    <= tail_in;
            hit_ff     <= hit_in;
            done_ff    <= done_in;
            dropped_ff <= dropped_in;
         end
         if (cmd_ready) begin
            out_valid_ff <= cmd_valid;
         end
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.event_valid   = hit_ff;
   assign rsp_bus.event_dx      = hit_ff ? rd_entry.dx : '0;
   assign rsp_bus.event_dy      = hit_ff ? rd_entry.dy : '0;
   assign rsp_bus.event_buttons = hit_ff ? rd_entry.buttons : '0;
   assign rsp_bus.position_x    = pos_x_ff;
   assign rsp_bus.position_y    = pos_y_ff;
   assign rsp_bus.button_state  = buttons_ff;
   assign rsp_bus.move_dx       = dx_ff;
   assign rsp_bus.move_dy       = dy_ff;
   assign rsp_bus.packet_done   = done_ff;
   assign rsp_bus.event_dropped = dropped_ff;
   assign rsp_bus.has_event     = (head_ff != tail_ff);

endmodule
`default_nettype wire

// ----- hdl/ps2_mouse_packet_tracker.sv -----
// Top level of the PS/2 mouse packet tracker: front, queue, back and CSRs.
//
// Usage:
//   req_bus carries one beat per mouse byte (req_type 0) or per event pop
//   (req_type 1). Every request beat yields exactly one rsp_bus beat, in order.
//   Bytes are grouped three to a packet; the third byte updates the position,
//   button state and latest deltas and pushes an event into a 128-slot ring
//   (127 usable), which is dropped and flagged when the ring is full.
//   A pop returns the oldest event, or event_valid 0 when the ring is empty.
//   A request beat is registered in the command queue, then in the back end's
//   response register, before its response appears on rsp_bus.
//   Throughput: one beat per cycle while rsp_bus.ready is high, set by the
//   back end and the one-write/one-read ring RAM port pair.
//   Backpressure: when rsp_bus.ready is low the back end holds its response
//   and the 4-entry command queue keeps accepting until full.
//   Reset (synchronous) sets position to 400,300, limits to 799,599, empties
//   the ring and restarts packet assembly. The CSR port holds x_limit at 0x0
//   and y_limit at 0x4; write limits only while the block is idle.
`default_nettype none
module ps2_mouse_packet_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   ps2mt_req_if.sink        req_bus,
   ps2mt_rsp_if.source      rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ps2mt_pkg::*;

   logic [POS_W-1:0] x_limit_ff;
   logic [POS_W-1:0] y_limit_ff;
   logic             csr_wr;
   logic             fq_valid, fq_ready;
   logic             qb_valid, qb_ready;
   cmd_type          fq_cmd, qb_cmd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_X_LIMIT: x_limit_ff <= csr_pwdata[POS_W-1:0];
            CSR_Y_LIMIT: y_limit_ff <= csr_pwdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_X_LIMIT: csr_prdata = {20'd0, x_limit_ff};
         CSR_Y_LIMIT: csr_prdata = {20'd0, y_limit_ff};
         default:     csr_prdata = '0;
      endcase
   end

   ps2mt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (fq_valid),
      .cmd       (fq_cmd),
      .cmd_ready (fq_ready)
   );

   ps2mt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_cmd    (fq_cmd),
      .in_ready  (fq_ready),
      .out_valid (qb_valid),
      .out_cmd   (qb_cmd),
      .out_ready (qb_ready)
   );

   ps2mt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd       (qb_cmd),
      .cmd_ready (qb_ready),
      .x_limit   (x_limit_ff),
      .y_limit   (y_limit_ff),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire
